FILE: hdl/segi_pkg.sv
// Shared types and codes for the segment intersection unit.
// No dependencies.
`default_nettype none
package segi_pkg;

  typedef enum logic [1:0] {
    ST_NONE      = 2'd0,
    ST_CROSS     = 2'd1,
    ST_COLLINEAR = 2'd2
  } seg_status_t;

endpackage
`default_nettype wire

FILE: hdl/segment_intersection_unit.sv
// Segment intersection unit: pipelined test of two line segments for a crossing.
// Depends on segi_pkg.
//
// One segment pair is taken per cycle unless the pipeline holds. The pipeline runs
// five stages of differences, products, the alpha, beta and denominator terms, the
// rejection tests and the scaling multiply. A restoring divider follows, with one
// quotient bit per stage (COORD_BITS + 1 stages), and then the output register.
// When the output beat is not taken, the whole pipeline holds.
`default_nettype none
module segment_intersection_unit #(
  parameter int COORD_BITS = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic signed [COORD_BITS-1:0] in_seg_a_start_x,
  input  wire logic signed [COORD_BITS-1:0] in_seg_a_start_y,
  input  wire logic signed [COORD_BITS-1:0] in_seg_a_end_x,
  input  wire logic signed [COORD_BITS-1:0] in_seg_a_end_y,
  input  wire logic signed [COORD_BITS-1:0] in_seg_b_start_x,
  input  wire logic signed [COORD_BITS-1:0] in_seg_b_start_y,
  input  wire logic signed [COORD_BITS-1:0] in_seg_b_end_x,
  input  wire logic signed [COORD_BITS-1:0] in_seg_b_end_y,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [1:0]                        out_status,
  output logic signed [COORD_BITS-1:0]      out_cross_x,
  output logic signed [COORD_BITS-1:0]      out_cross_y
);
  import segi_pkg::*;

  localparam int W  = COORD_BITS;
  localparam int DW = W + 1;
  localparam int PW = 2 * DW;
  localparam int VW = PW + 1;
  localparam int NW = VW + DW;
  localparam int RW = NW + 1;

  typedef struct packed {
    logic signed [W-1:0] x1;
    logic signed [W-1:0] y1;
    logic                rej;
    logic                fz;
    logic                negx;
    logic                negy;
    logic [RW-1:0]       remx;
    logic [RW-1:0]       remy;
    logic [DW-1:0]       qx;
    logic [DW-1:0]       qy;
    logic [VW-1:0]       den;
  } div_t;

  function automatic div_t div_step(input div_t s, input int sh);
    div_t          o;
    logic [RW-1:0] dsh;
    o   = s;
    dsh = RW'(s.den) << sh;
    if (s.remx >= dsh) begin
      o.remx = s.remx - dsh;
      o.qx   = {s.qx[DW-2:0], 1'b1};
    end else begin
      o.qx   = {s.qx[DW-2:0], 1'b0};
    end
    if (s.remy >= dsh) begin
      o.remy = s.remy - dsh;
      o.qy   = {s.qy[DW-2:0], 1'b1};
    end else begin
      o.qy   = {s.qy[DW-2:0], 1'b0};
    end
    return o;
  endfunction

  function automatic logic outside(input logic signed [VW-1:0] v,
                                   input logic signed [VW-1:0] f);
    logic r;
    if (f > 0) begin
      r = (v < 0) || (v > f);
    end else begin
      r = (v > 0) || (v < f);
    end
    return r;
  endfunction

  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // bounding boxes
  logic signed [W-1:0] alo_x, ahi_x, blo_x, bhi_x, alo_y, ahi_y, blo_y, bhi_y;
  logic                bbox_rej;
  always_comb begin
    if (in_seg_a_end_x < in_seg_a_start_x) begin
      alo_x = in_seg_a_end_x;   ahi_x = in_seg_a_start_x;
    end else begin
      alo_x = in_seg_a_start_x; ahi_x = in_seg_a_end_x;
    end
    if (in_seg_b_start_x > in_seg_b_end_x) begin
      blo_x = in_seg_b_end_x;   bhi_x = in_seg_b_start_x;
    end else begin
      blo_x = in_seg_b_start_x; bhi_x = in_seg_b_end_x;
    end
    if (in_seg_a_end_y < in_seg_a_start_y) begin
      alo_y = in_seg_a_end_y;   ahi_y = in_seg_a_start_y;
    end else begin
      alo_y = in_seg_a_start_y; ahi_y = in_seg_a_end_y;
    end
    if (in_seg_b_start_y > in_seg_b_end_y) begin
      blo_y = in_seg_b_end_y;   bhi_y = in_seg_b_start_y;
    end else begin
      blo_y = in_seg_b_start_y; bhi_y = in_seg_b_end_y;
    end
    bbox_rej = (ahi_x < blo_x) || (bhi_x < alo_x) || (ahi_y < blo_y) || (bhi_y < alo_y);
  end

  // stage 1: differences
  logic                 s1_v_r, s1_rej_r;
  logic signed [W-1:0]  s1_x1_r, s1_y1_r;
  logic signed [DW-1:0] s1_ax_r, s1_ay_r, s1_bx_r, s1_by_r, s1_cx_r, s1_cy_r;
  // stage 2: products
  logic                 s2_v_r, s2_rej_r;
  logic signed [W-1:0]  s2_x1_r, s2_y1_r;
  logic signed [DW-1:0] s2_ax_r, s2_ay_r;
  logic signed [PW-1:0] s2_bycx_r, s2_bxcy_r, s2_aybx_r, s2_axby_r, s2_axcy_r, s2_aycx_r;
  // stage 3: alpha, beta numerators and denominator
  logic                 s3_v_r, s3_rej_r;
  logic signed [W-1:0]  s3_x1_r, s3_y1_r;
  logic signed [DW-1:0] s3_ax_r, s3_ay_r;
  logic signed [VW-1:0] s3_d_r, s3_e_r, s3_f_r;
  // stage 4: tests, magnitudes, signs
  logic                 s4_v_r, s4_rej_r, s4_fz_r, s4_negx_r, s4_negy_r;
  logic signed [W-1:0]  s4_x1_r, s4_y1_r;
  logic [VW-1:0]        s4_dmag_r, s4_fmag_r;
  logic [DW-1:0]        s4_amx_r, s4_amy_r;
  // stage 5: scaled numerators
  logic                 s5_v_r, s5_rej_r, s5_fz_r, s5_negx_r, s5_negy_r;
  logic signed [W-1:0]  s5_x1_r, s5_y1_r;
  logic [NW-1:0]        s5_nx_r, s5_ny_r;
  logic [VW-1:0]        s5_fmag_r;
  // divider
  div_t                 div_r [0:DW];
  logic [DW:0]          div_v_r;

  logic                 s4_rej_nxt, s4_negx_nxt, s4_negy_nxt;
  logic [VW-1:0]        s4_dmag_nxt, s4_fmag_nxt;
  logic [DW-1:0]        s4_amx_nxt, s4_amy_nxt;
  always_comb begin
    s4_rej_nxt  = s3_rej_r || outside(s3_d_r, s3_f_r) || outside(s3_e_r, s3_f_r);
    s4_dmag_nxt = s3_d_r[VW-1] ? VW'(-s3_d_r) : VW'(s3_d_r);
    s4_fmag_nxt = s3_f_r[VW-1] ? VW'(-s3_f_r) : VW'(s3_f_r);
    s4_amx_nxt  = s3_ax_r[DW-1] ? DW'(-s3_ax_r) : DW'(s3_ax_r);
    s4_amy_nxt  = s3_ay_r[DW-1] ? DW'(-s3_ay_r) : DW'(s3_ay_r);
    s4_negx_nxt = ((s3_d_r != '0) && (s3_ax_r != '0) && (s3_d_r[VW-1] != s3_ax_r[DW-1]))
                  ^ s3_f_r[VW-1];
    s4_negy_nxt = ((s3_d_r != '0) && (s3_ay_r != '0) && (s3_d_r[VW-1] != s3_ay_r[DW-1]))
                  ^ s3_f_r[VW-1];
  end

  div_t div0_nxt;
  always_comb begin
    div0_nxt.x1   = s5_x1_r;
    div0_nxt.y1   = s5_y1_r;
    div0_nxt.rej  = s5_rej_r;
    div0_nxt.fz   = s5_fz_r;
    div0_nxt.negx = s5_negx_r;
    div0_nxt.negy = s5_negy_r;
    div0_nxt.remx = RW'(s5_nx_r) + RW'(s5_fmag_r >> 1);
    div0_nxt.remy = RW'(s5_ny_r) + RW'(s5_fmag_r >> 1);
    div0_nxt.qx   = '0;
    div0_nxt.qy   = '0;
    div0_nxt.den  = s5_fmag_r;
  end

  // final sign and offset
  div_t                 dl;
  logic signed [DW:0]   sx, sy;
  logic signed [DW:0]   sumx, sumy;
  seg_status_t          st_nxt;
  always_comb begin
    dl   = div_r[DW];
    sx   = dl.negx ? -$signed({1'b0, dl.qx}) : $signed({1'b0, dl.qx});
    sy   = dl.negy ? -$signed({1'b0, dl.qy}) : $signed({1'b0, dl.qy});
    sumx = $signed({{2{dl.x1[W-1]}}, dl.x1}) + sx;
    sumy = $signed({{2{dl.y1[W-1]}}, dl.y1}) + sy;
    if (dl.rej) begin
      st_nxt = ST_NONE;
    end else if (dl.fz) begin
      st_nxt = ST_COLLINEAR;
    end else begin
      st_nxt = ST_CROSS;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r    <= 1'b0;
      s2_v_r    <= 1'b0;
      s3_v_r    <= 1'b0;
      s4_v_r    <= 1'b0;
      s5_v_r    <= 1'b0;
      div_v_r   <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      s1_v_r    <= in_valid;
      s2_v_r    <= s1_v_r;
      s3_v_r    <= s2_v_r;
      s4_v_r    <= s3_v_r;
      s5_v_r    <= s4_v_r;
      div_v_r   <= {div_v_r[DW-1:0], s5_v_r};
      out_valid <= div_v_r[DW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_rej_r  <= bbox_rej;
      s1_x1_r   <= in_seg_a_start_x;
      s1_y1_r   <= in_seg_a_start_y;
      s1_ax_r   <= $signed({in_seg_a_end_x[W-1], in_seg_a_end_x})
                 - $signed({in_seg_a_start_x[W-1], in_seg_a_start_x});
      s1_ay_r   <= $signed({in_seg_a_end_y[W-1], in_seg_a_end_y})
                 - $signed({in_seg_a_start_y[W-1], in_seg_a_start_y});
      s1_bx_r   <= $signed({in_seg_b_start_x[W-1], in_seg_b_start_x})
                 - $signed({in_seg_b_end_x[W-1], in_seg_b_end_x});
      s1_by_r   <= $signed({in_seg_b_start_y[W-1], in_seg_b_start_y})
                 - $signed({in_seg_b_end_y[W-1], in_seg_b_end_y});
      s1_cx_r   <= $signed({in_seg_a_start_x[W-1], in_seg_a_start_x})
                 - $signed({in_seg_b_start_x[W-1], in_seg_b_start_x});
      s1_cy_r   <= $signed({in_seg_a_start_y[W-1], in_seg_a_start_y})
                 - $signed({in_seg_b_start_y[W-1], in_seg_b_start_y});

      s2_rej_r  <= s1_rej_r;
      s2_x1_r   <= s1_x1_r;
      s2_y1_r   <= s1_y1_r;
      s2_ax_r   <= s1_ax_r;
      s2_ay_r   <= s1_ay_r;
      s2_bycx_r <= s1_by_r * s1_cx_r;
      s2_bxcy_r <= s1_bx_r * s1_cy_r;
      s2_aybx_r <= s1_ay_r * s1_bx_r;
      s2_axby_r <= s1_ax_r * s1_by_r;
      s2_axcy_r <= s1_ax_r * s1_cy_r;
      s2_aycx_r <= s1_ay_r * s1_cx_r;

      s3_rej_r  <= s2_rej_r;
      s3_x1_r   <= s2_x1_r;
      s3_y1_r   <= s2_y1_r;
      s3_ax_r   <= s2_ax_r;
      s3_ay_r   <= s2_ay_r;
      s3_d_r    <= VW'(s2_bycx_r) - VW'(s2_bxcy_r);
      s3_f_r    <= VW'(s2_aybx_r) - VW'(s2_axby_r);
      s3_e_r    <= VW'(s2_axcy_r) - VW'(s2_aycx_r);

      s4_rej_r  <= s4_rej_nxt;
      s4_fz_r   <= (s3_f_r == '0);
      s4_negx_r <= s4_negx_nxt;
      s4_negy_r <= s4_negy_nxt;
      s4_x1_r   <= s3_x1_r;
      s4_y1_r   <= s3_y1_r;
      s4_dmag_r <= s4_dmag_nxt;
      s4_fmag_r <= s4_fmag_nxt;
      s4_amx_r  <= s4_amx_nxt;
      s4_amy_r  <= s4_amy_nxt;

      s5_rej_r  <= s4_rej_r;
      s5_fz_r   <= s4_fz_r;
      s5_negx_r <= s4_negx_r;
      s5_negy_r <= s4_negy_r;
      s5_x1_r   <= s4_x1_r;
      s5_y1_r   <= s4_y1_r;
      s5_nx_r   <= NW'(s4_dmag_r * s4_amx_r);
      s5_ny_r   <= NW'(s4_dmag_r * s4_amy_r);
      s5_fmag_r <= s4_fmag_r;

      div_r[0]  <= div0_nxt;
      for (int k = 0; k < DW; k++) begin
        div_r[k+1] <= div_step(div_r[k], DW - 1 - k);
      end

      out_status  <= st_nxt;
      out_cross_x <= (st_nxt == ST_CROSS) ? sumx[W-1:0] : '0;
      out_cross_y <= (st_nxt == ST_CROSS) ? sumy[W-1:0] : '0;
    end
  end

  a_zero_point: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_CROSS) |-> (out_cross_x == '0 && out_cross_y == '0))
    else $error("cross point not zero without a crossing");

  a_stall_keeps_last: assert property (@(posedge clk) disable iff (!rst_n)
    (div_v_r[DW] && !en) |=> div_v_r[DW])
    else $error("stalled item lost at divider output");

  a_ready_follows_out: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_status)))
    else $error("held result changed during stall");

endmodule
`default_nettype wire

FILE: tb/segment_intersection_unit_test.sv
// Testbench for segment_intersection_unit: random and directed segment pairs,
// results predicted in place and checked in order. Depends on segi_pkg and the RTL.
`timescale 1ns / 1ps
module segment_intersection_unit_test;
  import segi_pkg::*;

  localparam int CB = 16;
  localparam int LAT = CB + 7;

  typedef logic signed [CB-1:0] coord_t;
  typedef struct {
    coord_t c[8];
  } seg_pair_t;
  typedef struct {
    seg_status_t st;
    coord_t      x;
    coord_t      y;
  } crossing_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  coord_t in_c[8] = '{default: '0};
  logic out_valid;
  logic out_ready = 0;
  logic [1:0] out_status;
  coord_t out_cross_x, out_cross_y;

  seg_pair_t pending[$];
  crossing_t expected[$];
  int errors = 0;
  bit stim_done = 0;
  int hold_left = 0;
  bit held = 0;
  int burst_left = 0;
  int gap_left = 0;

  segment_intersection_unit #(.COORD_BITS(CB)) i_dut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_seg_a_start_x(in_c[0]), .in_seg_a_start_y(in_c[1]),
    .in_seg_a_end_x(in_c[2]), .in_seg_a_end_y(in_c[3]),
    .in_seg_b_start_x(in_c[4]), .in_seg_b_start_y(in_c[5]),
    .in_seg_b_end_x(in_c[6]), .in_seg_b_end_y(in_c[7]),
    .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
    .out_cross_x(out_cross_x), .out_cross_y(out_cross_y)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  function automatic longint rounded_share(longint num, longint len, longint den);
    longint q;
    longint an, ad;
    an = (num * len < 0) ? -(num * len) : num * len;
    ad = (den < 0) ? -den : den;
    q = (an + ad / 2) / ad;
    if (((num * len) < 0) != (den < 0)) q = -q;
    return q;
  endfunction

  function automatic bit out_of_span(longint v, longint f);
    if (f > 0) return v < 0 || v > f;
    return v > 0 || v < f;
  endfunction

  function automatic bit boxes_apart(longint p1, longint p2, longint p3, longint p4);
    longint lo, hi;
    lo = (p2 < p1) ? p2 : p1;
    hi = (p2 < p1) ? p1 : p2;
    if (p3 - p4 > 0) return hi < p4 || p3 < lo;
    return hi < p3 || p4 < lo;
  endfunction

  function automatic crossing_t predict_crossing(seg_pair_t s);
    crossing_t r;
    longint x1, y1, x2, y2, x3, y3, x4, y4, ax, ay, bx, by, cx, cy, d, e, f;
    x1 = s.c[0]; y1 = s.c[1]; x2 = s.c[2]; y2 = s.c[3];
    x3 = s.c[4]; y3 = s.c[5]; x4 = s.c[6]; y4 = s.c[7];
    r.st = ST_NONE; r.x = '0; r.y = '0;
    if (boxes_apart(x1, x2, x3, x4) || boxes_apart(y1, y2, y3, y4)) return r;
    ax = x2 - x1; ay = y2 - y1; bx = x3 - x4; by = y3 - y4;
    cx = x1 - x3; cy = y1 - y3;
    d = by * cx - bx * cy;
    f = ay * bx - ax * by;
    e = ax * cy - ay * cx;
    if (out_of_span(d, f) || out_of_span(e, f)) return r;
    if (f == 0) begin
      r.st = ST_COLLINEAR;
      return r;
    end
    r.st = ST_CROSS;
    r.x = coord_t'(x1 + rounded_share(d, ax, f));
    r.y = coord_t'(y1 + rounded_share(d, ay, f));
    return r;
  endfunction

  function automatic coord_t rand_coord(int span);
    if (span == 0) return coord_t'($urandom);
    return coord_t'($urandom_range(2 * span) - span);
  endfunction

  function automatic seg_pair_t make_pair(int a0, int a1, int a2, int a3,
                                          int b0, int b1, int b2, int b3);
    seg_pair_t s;
    s.c[0] = coord_t'(a0); s.c[1] = coord_t'(a1);
    s.c[2] = coord_t'(a2); s.c[3] = coord_t'(a3);
    s.c[4] = coord_t'(b0); s.c[5] = coord_t'(b1);
    s.c[6] = coord_t'(b2); s.c[7] = coord_t'(b3);
    return s;
  endfunction

  // likely-crossing pair: B straddles a point on A
  function automatic seg_pair_t crossing_pair(int span);
    seg_pair_t s;
    int mx, my, dx, dy;
    for (int i = 0; i < 4; i++) s.c[i] = rand_coord(span);
    mx = (int'(s.c[0]) + int'(s.c[2])) / 2;
    my = (int'(s.c[1]) + int'(s.c[3])) / 2;
    dx = int'(rand_coord(span / 2 + 1));
    dy = int'(rand_coord(span / 2 + 1));
    s.c[4] = coord_t'(mx + dx); s.c[5] = coord_t'(my + dy);
    s.c[6] = coord_t'(mx - dx); s.c[7] = coord_t'(my - dy);
    return s;
  endfunction

  initial begin
    seg_pair_t s;
    int spans[4] = '{8, 300, 16000, 0};
    pending.push_back(make_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
    pending.push_back(make_pair(32767, -32768, -32768, 32767, 32767, 32767, -32768, -32768));
    pending.push_back(make_pair(0, 0, 10, 0, 20, -5, 20, 5));
    pending.push_back(make_pair(0, 0, 10, 0, 5, 20, 5, 30));
    pending.push_back(make_pair(0, 0, 10, 10, 10, 0, 9, 1));
    pending.push_back(make_pair(0, 0, 10, 0, 5, 0, 20, 0));
    pending.push_back(make_pair(3, 3, 3, 3, 3, 3, 3, 3));
    pending.push_back(make_pair(0, 0, 10, 0, 10, 0, 10, 10));
    pending.push_back(make_pair(0, 0, 0, 0, -4, -4, 4, 4));
    pending.push_back(make_pair(0, 0, 3, 1, 1, 2, 2, -1));
    pending.push_back(make_pair(0, 0, -3, -1, -1, -2, -2, 1));
    pending.push_back(make_pair(0, 0, 1, 1, 0, 1, 1, 0));
    pending.push_back(make_pair(0, 0, 10, 10, 0, 1, 10, 11));
    pending.push_back(make_pair(-32768, 0, 32767, 0, 0, -32768, 0, 32767));
    pending.push_back(make_pair(-32768, -32768, 32767, -32767, -32768, -32767, 32767,
                                -32768));
    pending.push_back(make_pair(0, 0, 32767, 1, 1, 1, 2, -1));
    for (int n = 0; n < 700; n++) begin
      int k;
      k = $urandom_range(9);
      if (k < 6) s = crossing_pair(spans[$urandom_range(3)]);
      else if (k < 8) begin
        s = crossing_pair(spans[$urandom_range(2)]);
        s.c[6] = coord_t'(s.c[4] + 2 * (s.c[2] - s.c[0]));
        s.c[7] = coord_t'(s.c[5] + 2 * (s.c[3] - s.c[1]));
      end else for (int i = 0; i < 8; i++) s.c[i] = rand_coord(spans[$urandom_range(3)]);
      pending.push_back(s);
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) expected.push_back(predict_crossing(pending.pop_front()));
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending.size() > (in_valid && in_ready ? 0 : 0) &&
                     pending.size() > 0) begin
          in_valid <= 1'b1;
          for (int i = 0; i < 8; i++) in_c[i] <= pending[0].c[i];
          if (burst_left > 0) burst_left <= burst_left - 1;
          else begin
            burst_left <= $urandom_range(30);
            gap_left <= ($urandom_range(3) == 0) ? 0 : $urandom_range(6);
          end
        end else begin
          in_valid <= 1'b0;
          stim_done <= 1'b1;
        end
      end
    end
  end

  // receiver: mostly random stalls, one long hold-off early on
  int beats_seen = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_left <= 0;
    end else begin
      if (out_valid && out_ready) begin
        crossing_t w;
        beats_seen <= beats_seen + 1;
        if (expected.size() == 0) begin
          $error("unexpected beat status=%0d", out_status);
          errors++;
        end else begin
          w = expected.pop_front();
          if (out_status !== w.st) begin
            $error("status expected %0d actual %0d", w.st, out_status);
            errors++;
          end
          if (out_cross_x !== w.x) begin
            $error("cross_x expected %0d actual %0d", w.x, out_cross_x);
            errors++;
          end
          if (out_cross_y !== w.y) begin
            $error("cross_y expected %0d actual %0d", w.y, out_cross_y);
            errors++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (!held && beats_seen >= 40 && out_valid) begin
        held <= 1'b1;
        hold_left <= 200;
        out_ready <= 1'b0;
      end else if ((beats_seen / 64) % 2 == 1) out_ready <= 1'b1;
      else out_ready <= ($urandom_range(3) != 0);
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    wait (stim_done && expected.size() == 0);
    repeat (LAT + 10) @(posedge clk);
    if (errors == 0 && expected.size() == 0) $display("segment_intersection_unit_test: clean");
    else $display("segment_intersection_unit_test: errors");
    $finish;
  end

  initial begin
    #2000000;
    $display("segment_intersection_unit_test: errors");
    $finish;
  end
endmodule

FILE: files.f
hdl/segi_pkg.sv
hdl/segment_intersection_unit.sv
tb/segment_intersection_unit_test.sv
